@@ src/gpc_pkg.sv @@
// Shared types and constants for the grid path counter.
package gpc_pkg;

   // Register and field widths.
   localparam int SIDE_W      = 11;
   localparam int COUNT_W     = 30;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Defaults for the top level parameters and registers.
   localparam int DEF_MAX_SIDE = 1024;
   localparam int QUEUE_DEPTH  = 4;
   localparam logic [SIDE_W-1:0]  SIDE_RESET    = SIDE_W'(1);
   localparam logic [COUNT_W-1:0] MODULUS_RESET = COUNT_W'(1000000007);
   localparam logic [COUNT_W-1:0] MODULUS_MIN   = COUNT_W'(2);

   // Register index, taken from the word address of the configuration port.
   typedef enum logic {
      REG_GRID_SIDE = 1'b0,
      REG_MODULUS   = 1'b1
   } gpc_reg_type;

   // Classification of one cell, made by the front end.
   typedef struct packed {
      logic blocked;
      logic top_row;
      logic left_col;
      logic last;
   } gpc_flags_type;

   localparam int FLAGS_W = $bits(gpc_flags_type);

endpackage

@@ src/gpc_front.sv @@
// Front end: accepts cell requests, tracks the grid position and classifies each cell.
module gpc_front
   import gpc_pkg::*;
#(
   parameter int IDX_W = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart_i,
   input  logic [IDX_W-1:0]             side_m1_i,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_blocked,
   input  logic                         full_i,
   output logic                         push_o,
   output logic [IDX_W+FLAGS_W-1:0]     push_data_o
);

   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   gpc_flags_type    flags;
   logic             accept;

   assign req_ready = !full_i;
   assign accept    = req_valid && !full_i;
   assign push_o    = accept;

   // Classify the cell at the current position.
   always_comb begin
      flags.blocked  = req_blocked;
      flags.top_row  = (row_ff == '0);
      flags.left_col = (col_ff == '0);
      flags.last     = (row_ff == side_m1_i) && (col_ff == side_m1_i);
   end

   assign push_data_o = {col_ff, flags};

   // Advance in row-major order; return to the start after the last cell or on restart.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart_i) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (flags.last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_ff == side_m1_i) begin
            row_in = row_ff + IDX_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // After a restart the position is back at the first cell.
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      $past(restart_i) |-> (row_ff == '0) && (col_ff == '0))
      else $error("position not cleared after restart");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && flags.last && !restart_i |=> (row_ff == '0) && (col_ff == '0))
      else $error("position did not wrap after the last cell");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      accept && !flags.last && !restart_i && (col_ff == side_m1_i)
      |=> (col_ff == '0) && (row_ff == $past(row_ff) + IDX_W'(1)))
      else $error("row did not advance at the end of a row");

endmodule

@@ src/gpc_queue.sv @@
// Short queue of classified cells between the front end and the back end.
module gpc_queue
   import gpc_pkg::*;
#(
   parameter int DATA_W = 14,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  logic [DATA_W-1:0] push_data_i,
   output logic              full_o,
   input  logic              pop_i,
   output logic              valid_o,
   output logic [DATA_W-1:0] pop_data_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full_o     = (count_ff == CNT_W'(DEPTH));
   assign valid_o    = (count_ff != '0);
   assign do_push    = push_i && !full_o;
   assign do_pop     = pop_i && valid_o;
   assign pop_data_o = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

endmodule

@@ src/gpc_back.sv @@
// Back end: line store, modular add of neighbor counts and the result register.
module gpc_back
   import gpc_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE,
   parameter int IDX_W    = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart_i,
   input  logic [COUNT_W-1:0]       modulus_i,
   input  logic                     q_valid_i,
   input  logic [IDX_W+FLAGS_W-1:0] q_data_i,
   output logic                     pop_o,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COUNT_W-1:0]       rsp_path_count
);

   // Line store with the counts of the row above.
   logic [COUNT_W-1:0] row_mem [MAX_SIDE];

   logic                 a_valid_ff, a_valid_in;
   gpc_flags_type        a_flags_ff;
   logic [IDX_W-1:0]     a_col_ff;
   logic [COUNT_W-1:0]   up_ff;
   logic [COUNT_W-1:0]   left_ff, left_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 a_fire;
   logic [COUNT_W-1:0]   up_val, left_val, cell_val;
   logic [COUNT_W:0]     sum;
   logic [COUNT_W:0]     sum_red;
   gpc_flags_type        q_flags;
   logic [IDX_W-1:0]     q_col;

   assign {q_col, q_flags} = q_data_i;

   // A cell leaves the stage unless it carries a result that cannot be stored yet.
   assign a_fire = a_valid_ff && (!a_flags_ff.last || !rsp_valid_ff || rsp_ready);
   assign pop_o  = q_valid_i && (!a_valid_ff || a_fire);

   // Neighbor selection and one conditional subtraction of the modulus.
   always_comb begin
      up_val   = a_flags_ff.top_row  ? '0 : up_ff;
      left_val = a_flags_ff.left_col ? '0 : left_ff;
      sum      = {1'b0, up_val} + {1'b0, left_val};
      sum_red  = (sum >= {1'b0, modulus_i}) ? sum - {1'b0, modulus_i} : sum;
      if (a_flags_ff.blocked) begin
         cell_val = '0;
      end else if (a_flags_ff.top_row && a_flags_ff.left_col) begin
         cell_val = COUNT_W'(1);
      end else begin
         cell_val = sum_red[COUNT_W-1:0];
      end
   end

   // Line store: written as a cell completes, read as the next cell enters.
   always_ff @(posedge clock) begin
      if (a_fire) begin
         row_mem[a_col_ff] <= cell_val;
      end
      if (pop_o) begin
         up_ff <= row_mem[q_col];
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (pop_o) begin
         a_flags_ff <= q_flags;
         a_col_ff   <= q_col;
      end
      if (a_fire && a_flags_ff.last) begin
         rsp_count_ff <= cell_val;
      end
   end

   // Control state of the stage, the left count and the result register.
   always_comb begin
      a_valid_in   = pop_o ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);
      left_in      = restart_i ? '0 : (a_fire ? cell_val : left_ff);
      rsp_valid_in = rsp_valid_ff;
      if (a_fire && a_flags_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff < modulus_i)
      else $error("result not reduced below the modulus");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      a_fire && a_flags_ff.last |=> rsp_valid_ff)
      else $error("last cell completed without a result");

   a_stall_only_on_result: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_fire |-> a_flags_ff.last && rsp_valid_ff)
      else $error("stage stalled without a pending result");

endmodule

@@ src/grid_path_count_mod.sv @@
// Top level of the grid path counter: configuration registers and the two halves.
//
// Counts monotone right/down paths through a square grid with blocked cells,
// modulo a configured modulus. Each request on the req_ channel carries one
// cell (req_blocked) in row-major order. After the bottom-right cell of a grid
// the rsp_ channel delivers one result, rsp_path_count, and the position
// restarts for the next grid. Other cells produce no result.
// Throughput is one request per cycle while the queue is not full. The front
// end classifies a cell in the cycle it is accepted, the cell then waits in a
// four-entry queue, reads the line store entry of its column, and the modular
// add writes the count back; rsp_valid is registered after the queue and the
// stage register. The single line store read port and write port set this rate.
// When the receiver stalls, the result register holds and the queue fills;
// req_ready drops once the queue is full, and cells behind a pending result
// keep flowing until another last cell arrives.
// Reset clears the position, the left count, the queue and both valids, and
// sets grid_side to 1 and modulus to 1000000007. The line store needs no
// clearing. A register write restarts the grid position; the user must make
// it only while the block is idle, as the block itself does not enforce this.
module grid_path_count_mod
   import gpc_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_blocked,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_path_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DATA_W = IDX_W + FLAGS_W;
   localparam logic [31:0] MAX_SIDE_W = 32'(MAX_SIDE);

   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [COUNT_W-1:0] mod_ff, mod_in;
   logic               csr_write;
   gpc_reg_type        reg_sel;
   logic [31:0]        side_ext, side_eff, side_m1_ext;
   logic [IDX_W-1:0]   side_m1;
   logic [COUNT_W-1:0] mod_eff;
   logic               push, full, pop, q_valid;
   logic [DATA_W-1:0]  push_data, q_data;

   // Configuration port: every access completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = gpc_reg_type'(csr_paddr[2]);

   always_comb begin
      side_in = side_ff;
      mod_in  = mod_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_GRID_SIDE: side_in = csr_pwdata[SIDE_W-1:0];
            REG_MODULUS:   mod_in  = csr_pwdata[COUNT_W-1:0];
            default:       side_in = side_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         mod_ff  <= MODULUS_RESET;
      end else begin
         side_ff <= side_in;
         mod_ff  <= mod_in;
      end
   end

   // Register read back.
   always_comb begin
      unique case (reg_sel)
         REG_GRID_SIDE: csr_prdata = CSR_DATA_W'(side_ff);
         REG_MODULUS:   csr_prdata = CSR_DATA_W'(mod_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Clamp the side to one through MAX_SIDE and the modulus to at least two.
   always_comb begin
      side_ext = 32'(side_ff);
      if (side_ext == 32'd0) begin
         side_eff = 32'd1;
      end else if (side_ext > MAX_SIDE_W) begin
         side_eff = MAX_SIDE_W;
      end else begin
         side_eff = side_ext;
      end
      side_m1_ext = side_eff - 32'd1;
      side_m1     = side_m1_ext[IDX_W-1:0];
      mod_eff     = (mod_ff < MODULUS_MIN) ? MODULUS_MIN : mod_ff;
   end

   gpc_front #(
      .IDX_W (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart_i   (csr_write),
      .side_m1_i   (side_m1),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_blocked (req_blocked),
      .full_i      (full),
      .push_o      (push),
      .push_data_o (push_data)
   );

   gpc_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .full_o      (full),
      .pop_i       (pop),
      .valid_o     (q_valid),
      .pop_data_o  (q_data)
   );

   gpc_back #(
      .MAX_SIDE (MAX_SIDE),
      .IDX_W    (IDX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .restart_i      (csr_write),
      .modulus_i      (mod_eff),
      .q_valid_i      (q_valid),
      .q_data_i       (q_data),
      .pop_o          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_count (rsp_path_count)
   );

endmodule
